>>> design/assert_macros.svh
// shared assertion macros, sampled on the rising edge of clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define RCFR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define RCFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rcfr_pkg.sv
`timescale 1ns / 1ps

package rcfr_pkg;

    localparam int S_DATA_W   = 16;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FRAME_BODY = 6;
    localparam int POS_W      = 3;
    localparam logic [POS_W-1:0] LAST_POS = 3'd6;

    // item kinds on the input tuser
    typedef enum logic [1:0] {
        CMD_RX_BYTE   = 2'd0,
        CMD_CNT_RESET = 2'd1,
        CMD_BUTTON    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DRIVE_STOP = 2'd0,
        DRIVE_UP   = 2'd1,
        DRIVE_DOWN = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        REG_ADDRESS   = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_CNT_RESET = 2'd2,
        REG_CNT_START = 2'd3
    } reg_idx_t;

    // command bytes carried in a frame
    localparam logic [7:0] FCMD_UP   = 8'h20;
    localparam logic [7:0] FCMD_HOLD = 8'h22;
    localparam logic [7:0] FCMD_DOWN = 8'h24;

    // register reset values
    localparam logic [7:0]  ADDRESS_RST   = 8'h44;
    localparam logic [7:0]  WINDOW_RST    = 8'h20;
    localparam logic [15:0] CNT_RESET_RST = 16'd150;
    localparam logic [15:0] CNT_START_RST = 16'd0;

    typedef logic [FRAME_BODY-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic       button_up;
        logic       button_hold;
        logic       button_down;
        logic       upper_limit;
        logic       lower_limit;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] rcv_counter;
        logic [7:0]  cmd_byte;
    } check_t;

    typedef struct packed {
        logic [1:0]  motor_drive;
        logic        frame_complete;
        logic        frame_accepted;
        logic [7:0]  accepted_command;
        logic [15:0] counter_value;
        logic        counter_write;
    } result_t;

    localparam logic [7:0] BOX_HI [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] BOX_LO [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h86, 8'h59, 8'h47,
        8'hf0, 8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hd9, 8'hea,
        8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h68, 8'h05,
        8'h9a, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'h65, 8'h7a, 8'hae, 8'h08, 8'h15,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'hc1, 8'h1d, 8'h9e, 8'hc0,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'h8e, 8'h94, 8'h9b,
        8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf, 8'h31,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h41,
        8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16, 8'h07
    };

endpackage

>>> design/rcfr_frame_store.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rcfr_frame_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    output rcfr_pkg::frame_bytes_t frame,
    output logic                  last_byte
);
    import rcfr_pkg::*;

    logic [POS_W-1:0] pos_reg;
    frame_bytes_t     bytes_reg;

    assign last_byte = (pos_reg == LAST_POS);
    assign frame     = bytes_reg;

    // byte position; the seventh byte closes the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (byte_valid)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // frame body, no reset
    always_ff @(posedge clk)
    begin
        if (byte_valid && !last_byte)
        begin
            bytes_reg[pos_reg] <= rx_byte;
        end
    end

    `RCFR_ASSERT(pos_in_range_a, pos_reg <= LAST_POS, "byte position past end of frame")
    `RCFR_ASSERT_NEXT(pos_wrap_a, byte_valid && last_byte, pos_reg == '0,
        "byte position did not restart after frame")

endmodule

>>> design/rcfr_frame_check.sv
`timescale 1ns / 1ps

module rcfr_frame_check (
    input  rcfr_pkg::frame_bytes_t frame,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            expected_counter,
    input  logic [7:0]             receiver_address,
    input  logic [7:0]             window_len,
    output rcfr_pkg::check_t       check
);
    import rcfr_pkg::*;

    logic [7:0]  sum;
    logic [7:0]  hi_cnt;
    logic [7:0]  lo_cnt;
    logic [7:0]  hi_chk;
    logic [7:0]  lo_chk;
    logic [15:0] rcv;
    logic [15:0] ahead;
    logic        addr_ok;
    logic        sum_ok;
    logic        window_ok;
    logic        code_ok;

    // checksum is the low byte of the sum of the six body bytes
    assign sum = frame[0] + frame[1] + frame[2] + frame[3] + frame[4] + frame[5];

    // nibble interleave of the four code bytes
    assign hi_cnt = {frame[1][7:4], frame[2][3:0]};
    assign lo_cnt = {frame[3][7:4], frame[4][3:0]};
    assign hi_chk = {frame[2][7:4], frame[1][3:0]};
    assign lo_chk = {frame[4][7:4], frame[3][3:0]};
    assign rcv    = {hi_cnt, lo_cnt};

    // forward distance, wraps at 16 bits
    assign ahead = rcv - expected_counter;

    assign addr_ok   = (frame[0] == receiver_address);
    assign sum_ok    = (rx_byte == sum);
    assign window_ok = (ahead < {8'h00, window_len});
    assign code_ok   = (BOX_HI[BOX_HI[hi_cnt]] == hi_chk) && (BOX_LO[BOX_LO[lo_cnt]] == lo_chk);

    assign check.ok          = addr_ok && sum_ok && window_ok && code_ok;
    assign check.rcv_counter = rcv;
    assign check.cmd_byte    = frame[5];

endmodule

>>> design/rolling_code_frame_receiver.sv
`timescale 1ns / 1ps

// rolling code frame receiver with motor drive control
//
// input stream s_*: one request per serial byte or event; tuser carries the
//   kind (received byte, counter reset, button event), tdata the byte, the
//   buttons and the end switches
// output stream m_*: one result request per input request, in order
// cfg_*: register writes, always ready; issue them only while no request
//   is in flight
//
// timing: a result is offered from the result register after its request has
//   passed the input register; one request per cycle is sustained while m_tready
//   stays high, set by the single check pass between the two registers
// when m_tready is low the result register holds and the input register
//   keeps taking one more request, after which s_tready drops
// reset: frame position back to the first byte, drive stopped, registers at
//   their defaults, expected counter at the start value; the frame bytes
//   themselves are not cleared
// a frame is seven bytes: address, four code bytes, command byte, checksum

`include "assert_macros.svh"

module rolling_code_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rx_byte[7:0], button_up, button_hold, button_down, upper_limit,
    // lower_limit, zero pad
    input  logic [rcfr_pkg::S_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [rcfr_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // motor_drive[1:0], frame_complete, frame_accepted, accepted_command[7:0],
    // counter_value[15:0], counter_write, zero pad
    output logic [rcfr_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rcfr_pkg::*;

    item_t        in_reg;
    logic         in_valid_reg;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;
    logic         advance;
    cmd_t         cmd;
    reg_idx_t     cfg_reg;
    logic         cfg_wr;

    logic [7:0]   address_reg;
    logic [7:0]   window_reg;
    logic [15:0]  cnt_reset_reg;
    logic [15:0]  counter_reg;
    logic [15:0]  counter_next;
    drive_t       drive_reg;
    drive_t       drive_next;

    logic         byte_valid;
    logic         last_byte;
    frame_bytes_t frame;
    check_t       check;

    // pipeline handshake: the input register moves on when the result
    // register is empty or being emptied
    assign advance   = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = res_valid_reg;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_reg   = reg_idx_t'(cfg_index);

    assign m_tdata = {3'b000, res_reg.counter_write, res_reg.counter_value,
                      res_reg.accepted_command, res_reg.frame_accepted,
                      res_reg.frame_complete, res_reg.motor_drive};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.command     <= s_tuser[1:0];
            in_reg.rx_byte     <= s_tdata[7:0];
            in_reg.button_up   <= s_tdata[8];
            in_reg.button_hold <= s_tdata[9];
            in_reg.button_down <= s_tdata[10];
            in_reg.upper_limit <= s_tdata[11];
            in_reg.lower_limit <= s_tdata[12];
        end
    end

    assign cmd        = cmd_t'(in_reg.command);
    assign byte_valid = advance && (cmd == CMD_RX_BYTE);

    rcfr_frame_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (in_reg.rx_byte),
        .frame      (frame),
        .last_byte  (last_byte)
    );

    rcfr_frame_check u_check (
        .frame            (frame),
        .rx_byte          (in_reg.rx_byte),
        .expected_counter (counter_reg),
        .receiver_address (address_reg),
        .window_len       (window_reg),
        .check            (check)
    );

    // next drive, counter and result flags for the item in the input register
    always_comb
    begin
        drive_next                = drive_reg;
        counter_next              = counter_reg;
        res_next.frame_complete   = 1'b0;
        res_next.frame_accepted   = 1'b0;
        res_next.accepted_command = 8'h00;
        res_next.counter_write    = 1'b0;
        unique case (cmd)
            CMD_RX_BYTE:
            begin
                if (last_byte)
                begin
                    res_next.frame_complete = 1'b1;
                    if (check.ok)
                    begin
                        res_next.frame_accepted   = 1'b1;
                        res_next.accepted_command = check.cmd_byte;
                        res_next.counter_write    = 1'b1;
                        counter_next              = check.rcv_counter;
                        // unknown command bytes leave the drive alone
                        priority if (check.cmd_byte == FCMD_UP)
                        begin
                            drive_next = in_reg.upper_limit ? DRIVE_STOP : DRIVE_UP;
                        end
                        else if (check.cmd_byte == FCMD_HOLD)
                        begin
                            drive_next = DRIVE_STOP;
                        end
                        else if (check.cmd_byte == FCMD_DOWN)
                        begin
                            drive_next = in_reg.lower_limit ? DRIVE_STOP : DRIVE_DOWN;
                        end
                    end
                end
            end
            CMD_CNT_RESET:
            begin
                counter_next = cnt_reset_reg;
            end
            CMD_BUTTON:
            begin
                // up wins, then hold or any end switch stops, then down
                priority if (in_reg.button_up)
                begin
                    drive_next = in_reg.upper_limit ? DRIVE_STOP : DRIVE_UP;
                end
                else if (in_reg.button_hold || in_reg.upper_limit || in_reg.lower_limit)
                begin
                    drive_next = DRIVE_STOP;
                end
                else if (in_reg.button_down)
                begin
                    drive_next = DRIVE_DOWN;
                end
            end
            default:
            begin
                // unused kind: report current state only
            end
        endcase
        res_next.motor_drive   = drive_next;
        res_next.counter_value = counter_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg   <= ADDRESS_RST;
            window_reg    <= WINDOW_RST;
            cnt_reset_reg <= CNT_RESET_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg)
                REG_ADDRESS:   address_reg   <= cfg_data[7:0];
                REG_WINDOW:    window_reg    <= cfg_data[7:0];
                REG_CNT_RESET: cnt_reset_reg <= cfg_data;
                REG_CNT_START: ;
                default:       ;
            endcase
        end
    end

    // expected counter and drive; writing the start value also loads the counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= CNT_START_RST;
            drive_reg   <= DRIVE_STOP;
        end
        else
        begin
            if (cfg_wr && (cfg_reg == REG_CNT_START))
            begin
                counter_reg <= cfg_data;
            end
            else if (advance)
            begin
                counter_reg <= counter_next;
            end
            if (advance)
            begin
                drive_reg <= drive_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    `RCFR_ASSERT_IMPL(accept_in_frame_a, m_tvalid && res_reg.frame_accepted,
        res_reg.frame_complete, "accepted result without a completed frame")
    `RCFR_ASSERT_IMPL(write_on_accept_a, m_tvalid,
        res_reg.counter_write == res_reg.frame_accepted, "counter write not tied to accept")
    `RCFR_ASSERT_IMPL(cmd_zero_a, m_tvalid && !res_reg.frame_accepted,
        res_reg.accepted_command == 8'h00, "command byte shown for a rejected item")
    `RCFR_ASSERT_NEXT(counter_hold_a,
        !cfg_wr && !(advance && (cmd == CMD_CNT_RESET)) && !(byte_valid && last_byte),
        counter_reg == $past(counter_reg), "expected counter moved without cause")

endmodule

>>> tb/rcfr_frame_checker.sv
`timescale 1ns / 1ps

// watches the three channels, predicts every result and compares it
module rcfr_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rcfr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [rcfr_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rcfr_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              frames_done,
    output int                              frames_taken
);
    import rcfr_pkg::*;

    localparam logic [7:0]  ADDR_DEFAULT   = 8'd68;
    localparam logic [7:0]  WINDOW_DEFAULT = 8'd32;
    localparam logic [15:0] RELOAD_DEFAULT = 16'd150;
    localparam logic [15:0] START_DEFAULT  = 16'd0;
    localparam logic [2:0]  SUM_POS        = 3'd6;
    localparam int          PRINT_CAP      = 40;

    // substitution tables for the code check, entry 0 first
    localparam logic [0:255][7:0] SBOX_HI = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] SBOX_LO = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa865947f0add4a2af9ca472,
        128'hb7fd9326363fd9eaf7cc34a5e5f171d8,
        128'h04c723c3189668059a1280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4657aae0815,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b9c11d9ec0,
        128'he1f89811698e949b1e87e9ce5528df31,
        128'h8ca1890dbfe64241992d0fb054bb1607
    };

    logic [7:0]  my_addr;
    logic [7:0]  my_window;
    logic [15:0] my_reload;
    logic [2:0]  rx_pos;
    logic [7:0]  body [FRAME_BODY];
    logic [15:0] exp_counter;
    drive_t      drive;
    result_t     results_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t: mismatch in %s, got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // one request through the receiver, returns the result it should give
    function automatic result_t advance_receiver(input item_t it);
        result_t     r;
        logic [7:0]  sum;
        logic [7:0]  hi_cnt;
        logic [7:0]  lo_cnt;
        logic [7:0]  hi_chk;
        logic [7:0]  lo_chk;
        logic [15:0] rcv;
        r = '0;
        if (it.command == CMD_RX_BYTE) begin
            if (rx_pos < SUM_POS) begin
                body[rx_pos] = it.rx_byte;
                rx_pos = rx_pos + 3'd1;
            end
            else begin
                rx_pos = '0;
                r.frame_complete = 1'b1;
                sum = body[0] + body[1] + body[2] + body[3] + body[4] + body[5];
                // counter and check bytes are nibble interleaved
                hi_cnt = {body[1][7:4], body[2][3:0]};
                lo_cnt = {body[3][7:4], body[4][3:0]};
                hi_chk = {body[2][7:4], body[1][3:0]};
                lo_chk = {body[4][7:4], body[3][3:0]};
                rcv = {hi_cnt, lo_cnt};
                if (body[0] == my_addr && it.rx_byte == sum &&
                    16'(rcv - exp_counter) < {8'd0, my_window} &&
                    SBOX_HI[SBOX_HI[hi_cnt]] == hi_chk &&
                    SBOX_LO[SBOX_LO[lo_cnt]] == lo_chk) begin
                    r.frame_accepted = 1'b1;
                    r.accepted_command = body[5];
                    r.counter_write = 1'b1;
                    if (body[5] == FCMD_UP)
                        drive = it.upper_limit ? DRIVE_STOP : DRIVE_UP;
                    else if (body[5] == FCMD_HOLD)
                        drive = DRIVE_STOP;
                    else if (body[5] == FCMD_DOWN)
                        drive = it.lower_limit ? DRIVE_STOP : DRIVE_DOWN;
                    exp_counter = rcv;
                end
            end
        end
        else if (it.command == CMD_CNT_RESET) begin
            exp_counter = my_reload;
        end
        else if (it.command == CMD_BUTTON) begin
            // up wins, then hold or any end switch, then down
            if (it.button_up)
                drive = it.upper_limit ? DRIVE_STOP : DRIVE_UP;
            else if (it.button_hold || it.upper_limit || it.lower_limit)
                drive = DRIVE_STOP;
            else if (it.button_down)
                drive = it.lower_limit ? DRIVE_STOP : DRIVE_DOWN;
        end
        r.motor_drive = drive;
        r.counter_value = exp_counter;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        item_t   it;
        result_t due;
        if (!rst_n) begin
            my_addr = ADDR_DEFAULT;
            my_window = WINDOW_DEFAULT;
            my_reload = RELOAD_DEFAULT;
            exp_counter = START_DEFAULT;
            drive = DRIVE_STOP;
            rx_pos = '0;
            results_due.delete();
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ADDRESS:   my_addr = cfg_data[7:0];
                    REG_WINDOW:    my_window = cfg_data[7:0];
                    REG_CNT_RESET: my_reload = cfg_data;
                    REG_CNT_START: exp_counter = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with none due", m_tdata, '0);
                end
                else begin
                    due = results_due.pop_front();
                    if (m_tdata[1:0] !== due.motor_drive)
                        report_mismatch("motor_drive", m_tdata[1:0], due.motor_drive);
                    if (m_tdata[2] !== due.frame_complete)
                        report_mismatch("frame_complete", m_tdata[2], due.frame_complete);
                    if (m_tdata[3] !== due.frame_accepted)
                        report_mismatch("frame_accepted", m_tdata[3], due.frame_accepted);
                    if (m_tdata[11:4] !== due.accepted_command)
                        report_mismatch("accepted_command", m_tdata[11:4],
                                        due.accepted_command);
                    if (m_tdata[27:12] !== due.counter_value)
                        report_mismatch("counter_value", m_tdata[27:12], due.counter_value);
                    if (m_tdata[28] !== due.counter_write)
                        report_mismatch("counter_write", m_tdata[28], due.counter_write);
                end
            end
            if (s_tvalid && s_tready) begin
                it.command = s_tuser;
                it.rx_byte = s_tdata[7:0];
                it.button_up = s_tdata[8];
                it.button_hold = s_tdata[9];
                it.button_down = s_tdata[10];
                it.upper_limit = s_tdata[11];
                it.lower_limit = s_tdata[12];
                due = advance_receiver(it);
                if (due.frame_complete)
                    frames_done++;
                if (due.frame_accepted)
                    frames_taken++;
                results_due.push_back(due);
            end
            pending = results_due.size();
        end
    end

endmodule

>>> tb/tb_rolling_code_frame_receiver.sv
`timescale 1ns / 1ps

module tb_rolling_code_frame_receiver;
    import rcfr_pkg::*;

    localparam int         IDLE_PCT      = 22;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_ITEMS  = 1700;
    localparam int         PHASES        = 8;
    localparam int         ZERO_WIN_PART = 80;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_HI_CHECK,
        FLAW_LO_CHECK
    } flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int frames_done;
    int frames_taken;

    // stimulus side view of the receiver, only used to shape frames
    logic [7:0]  trk_addr = ADDRESS_RST;
    logic [7:0]  trk_window = WINDOW_RST;
    logic [15:0] trk_reload = CNT_RESET_RST;
    logic [15:0] trk_counter = CNT_START_RST;
    int          frame_pos = 0;
    int          n_sent = 0;
    int          n_settings = 1;
    bit          stall_on = 1'b1;
    int          quiet_cycles = 0;

    rolling_code_frame_receiver dut (.*);

    rcfr_frame_checker watcher (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: any request moving on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // every field but the kind random, end switches set less often so the drive moves
    function automatic item_t rand_item(input logic [1:0] kind);
        item_t it;
        it.command = kind;
        it.rx_byte = 8'($urandom);
        it.button_up = 1'($urandom);
        it.button_hold = 1'($urandom);
        it.button_down = 1'($urandom);
        it.upper_limit = ($urandom_range(99) < 25);
        it.lower_limit = ($urandom_range(99) < 25);
        return it;
    endfunction

    // mostly the three drive commands, sometimes any byte
    function automatic logic [7:0] frame_command();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return FCMD_UP;
        else if (pick < 5)
            return FCMD_HOLD;
        else if (pick < 8)
            return FCMD_DOWN;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] code_ahead(input int lo, input int hi);
        return trk_counter + 16'($urandom_range(hi, lo));
    endfunction

    // one input request, with random gaps ahead of it while stall_on is set
    task automatic push_request(input item_t it);
        while (stall_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.command;
        s_tdata <= {3'b000, it.lower_limit, it.upper_limit, it.button_down,
                    it.button_hold, it.button_up, it.rx_byte};
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
        if (it.command == CMD_RX_BYTE)
            frame_pos = (frame_pos == FRAME_BODY) ? 0 : frame_pos + 1;
        else if (it.command == CMD_CNT_RESET)
            trk_counter = trk_reload;
    endtask

    // seven byte frame, realigned first; an optional event lands mid frame
    task automatic send_frame(input logic [7:0] addr, input logic [15:0] code,
                              input logic [7:0] cmd_byte, input flaw_t flaw,
                              input bit with_event);
        logic [7:0] hi_chk;
        logic [7:0] lo_chk;
        logic [7:0] bytes [FRAME_BODY+1];
        item_t      it;
        int         spot;
        while (frame_pos != 0)
            push_request(rand_item(CMD_RX_BYTE));
        hi_chk = BOX_HI[BOX_HI[code[15:8]]];
        lo_chk = BOX_LO[BOX_LO[code[7:0]]];
        if (flaw == FLAW_HI_CHECK)
            hi_chk ^= 8'($urandom_range(255, 1));
        if (flaw == FLAW_LO_CHECK)
            lo_chk ^= 8'($urandom_range(255, 1));
        bytes[0] = addr;
        bytes[1] = {code[15:12], hi_chk[3:0]};
        bytes[2] = {hi_chk[7:4], code[11:8]};
        bytes[3] = {code[7:4], lo_chk[3:0]};
        bytes[4] = {lo_chk[7:4], code[3:0]};
        bytes[5] = cmd_byte;
        bytes[6] = bytes[0] + bytes[1] + bytes[2] + bytes[3] + bytes[4] + bytes[5];
        if (flaw == FLAW_SUM)
            bytes[6] ^= 8'($urandom_range(255, 1));
        spot = with_event ? $urandom_range(6, 1) : FRAME_BODY + 1;
        for (int k = 0; k <= FRAME_BODY; k++)
        begin
            // button or unused-code event, never a counter reset
            if (k == spot)
                push_request(rand_item($urandom_range(1) ? CMD_BUTTON : CMD_UNUSED));
            it = rand_item(CMD_RX_BYTE);
            it.rx_byte = bytes[k];
            push_request(it);
        end
        if (flaw == FLAW_NONE && addr == trk_addr &&
            16'(code - trk_counter) < {8'd0, trk_window})
            trk_counter = code;
    endtask

    // leaves cfg_valid high, the caller lowers it after the last write
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        item_t       it;
        int          target;
        int          first;
        int          reach;
        logic [7:0]  new_addr;
        logic [7:0]  new_win;
        logic [15:0] new_reload;
        logic [15:0] new_start;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused code, button priorities, frames around the window edge
        push_request(rand_item(CMD_UNUSED));
        it = rand_item(CMD_BUTTON);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b10000;
        push_request(it);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b10010;
        push_request(it);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b00100;
        push_request(it);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b01100;
        push_request(it);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b00101;
        push_request(it);
        {it.button_up, it.button_hold, it.button_down, it.upper_limit, it.lower_limit} = 5'b00010;
        push_request(it);
        // event in the middle must not break the frame
        send_frame(ADDRESS_RST, 16'd5, FCMD_UP, FLAW_NONE, 1'b1);
        push_request(rand_item(CMD_CNT_RESET));
        send_frame(ADDRESS_RST, CNT_RESET_RST + WINDOW_RST - 16'd1, FCMD_DOWN, FLAW_NONE, 1'b0);
        send_frame(ADDRESS_RST, trk_counter + WINDOW_RST, FCMD_HOLD, FLAW_NONE, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    new_addr = 8'h00;
                    new_win = 8'd1;
                    new_reload = 16'h0000;
                    new_start = 16'hffff;
                end
                1:
                begin
                    // counter wraps through zero inside a wide window
                    new_addr = 8'hff;
                    new_win = 8'd255;
                    new_reload = 16'hffff;
                    new_start = 16'hfff0;
                end
                2:
                begin
                    // zero window, nothing may pass
                    new_addr = 8'($urandom);
                    new_win = 8'd0;
                    new_reload = 16'($urandom);
                    new_start = 16'($urandom);
                end
                default:
                begin
                    new_addr = 8'($urandom);
                    new_win = $urandom_range(1) ? 8'($urandom_range(255, 1))
                                                : 8'($urandom_range(4, 1));
                    new_reload = 16'($urandom);
                    new_start = 16'($urandom);
                end
            endcase
            write_reg(REG_ADDRESS, {8'd0, new_addr});
            write_reg(REG_WINDOW, {8'd0, new_win});
            write_reg(REG_CNT_RESET, new_reload);
            // start value also reloads the counter, so keep it on some phases
            if (phase < 3 || phase % 2 == 1)
            begin
                write_reg(REG_CNT_START, new_start);
                trk_counter = new_start;
            end
            cfg_valid <= 1'b0;
            trk_addr = new_addr;
            trk_window = new_win;
            trk_reload = new_reload;
            n_settings++;
            // one phase runs with no gaps on either side
            stall_on <= (phase != 4);

            target = (phase == 2) ? ZERO_WIN_PART
                                  : (RANDOM_ITEMS - ZERO_WIN_PART) / (PHASES - 1);
            first = n_sent;
            while (n_sent - first < target)
            begin
                reach = (trk_window == 0) ? 0 : trk_window - 1;
                case ($urandom_range(99)) inside
                    [0:54]:
                        send_frame(trk_addr, code_ahead(0, reach), frame_command(), FLAW_NONE,
                                   $urandom_range(99) < 20);
                    [55:69]:
                    begin
                        // broken frames, one flaw each
                        case ($urandom_range(4))
                            0: send_frame(trk_addr ^ 8'($urandom_range(255, 1)),
                                          code_ahead(0, reach), frame_command(),
                                          FLAW_NONE, 1'b0);
                            1: send_frame(trk_addr, code_ahead(trk_window, 65535),
                                          frame_command(), FLAW_NONE, 1'b0);
                            2: send_frame(trk_addr, code_ahead(0, reach), frame_command(),
                                          FLAW_SUM, 1'b0);
                            3: send_frame(trk_addr, code_ahead(0, reach), frame_command(),
                                          FLAW_HI_CHECK, 1'b0);
                            default: send_frame(trk_addr, code_ahead(0, reach),
                                                frame_command(), FLAW_LO_CHECK, 1'b0);
                        endcase
                    end
                    [70:77]: push_request(rand_item(CMD_CNT_RESET));
                    [78:89]: push_request(rand_item(CMD_BUTTON));
                    [90:93]: push_request(rand_item(CMD_UNUSED));
                    // stray byte, throws framing off until the next realign
                    default: push_request(rand_item(CMD_RX_BYTE));
                endcase
            end
        end

        settle();
        $display("sent %0d requests under %0d register settings", n_sent, n_settings);
        $display("%0d frames completed, %0d of them accepted", frames_done, frames_taken);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/rcfr_pkg.sv
design/rcfr_frame_store.sv
design/rcfr_frame_check.sv
design/rolling_code_frame_receiver.sv
tb/rcfr_frame_checker.sv
tb/tb_rolling_code_frame_receiver.sv
